@@ design/rwcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rwcp_pkg: shared types and constants for the RIFF/WAVE chunk parser
// Chunk ids, parser phase and chunk type codes, result kinds, result record.
// ----------------------------------------------------------------------------
package rwcp_pkg;

    // Chunk and header ids, first byte in the top bits
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    // Format field bytes in a result, whatever the store depth
    localparam int FMT_FIELD_BYTES = 18;

    // Result queue
    localparam int QDEPTH  = 4;
    localparam int Q_PTR_W = $clog2(QDEPTH);
    localparam int Q_CNT_W = $clog2(QDEPTH + 1);

    // Header byte positions
    localparam logic [3:0] HDR_RIFF_LAST = 4'd3;
    localparam logic [3:0] HDR_LAST      = 4'd11;
    localparam logic [3:0] CHDR_ID_LEN   = 4'd4;
    localparam logic [3:0] CHDR_LAST     = 4'd7;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CHDR    = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_PAD     = 6'b001000,
        PH_DONE    = 6'b010000,
        PH_FAIL    = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        CT_OTHER = 2'd0,
        CT_FMT   = 2'd1,
        CT_DATA  = 2'd2
    } chunk_type_t;

    typedef enum logic [2:0] {
        KIND_PCM     = 3'd0,
        KIND_FMT     = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_BAD_HDR = 3'd3,
        KIND_MISSING = 3'd4
    } kind_t;

    typedef struct packed {
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_align;
        logic [15:0] sample_bits;
        logic [15:0] extra_size;
    } fmt_fields_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pcm_byte;
        logic        chunk_first;
        fmt_fields_t fmt;
        logic        final_res;
    } res_t;

endpackage

@@ design/riff_wave_chunk_parser_unit.sv @@
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_unit: RIFF/WAVE header check and chunk walker
// Captures fmt chunk fields and streams data chunk payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the file one byte a request; tlast marks the last byte.
//   m_axis carries result records: tuser is the kind (pcm byte, format
//   captured, done, bad header, chunk missing), tlast marks the last result
//   a byte caused. A byte causes zero, one or two results.
//   Each accepted byte is parsed in the cycle it is taken; its results are
//   registered into a four-entry result queue whose head drives m_axis. One
//   byte a cycle is taken while the queue has at least two free entries, so
//   the input runs at one byte a cycle while the receiver keeps up; a byte
//   that ends a chunk may cause two results.
//   When the receiver stalls the queue fills and s_axis_tready drops; nothing
//   is lost. After the byte marked tlast all parse state returns to its reset
//   value, ready for the next file. Reset empties the queue and clears the
//   format store; the block takes bytes from the first cycle after reset.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_unit #(
    parameter int FMT_BYTES = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] in_byte
    input  logic         s_axis_tlast,  // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] pcm_byte, [8] chunk_first, [24:9] format_tag, [40:25] channel_count,
    // [72:41] sample_rate, [104:73] byte_rate, [120:105] frame_align,
    // [136:121] sample_bits, [152:137] extra_size, [159:153] zero
    output logic [159:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,  // [2:0] kind
    output logic         m_axis_tlast   // final_res
);

    localparam int FMT_BYTES_C = (FMT_BYTES < rwcp_pkg::FMT_FIELD_BYTES) ?
                                 FMT_BYTES : rwcp_pkg::FMT_FIELD_BYTES;

    // Parse state
    rwcp_pkg::phase_t      phase_reg, phase_next;
    logic [3:0]            byte_cnt_reg, byte_cnt_next;
    logic [31:0]           id_reg, id_next;
    logic [31:0]           size_reg, size_next;
    logic [31:0]           remaining_reg, remaining_next;
    rwcp_pkg::chunk_type_t ctype_reg, ctype_next;
    logic                  pad_reg, pad_next;
    logic                  found_fmt_reg, found_fmt_next;
    logic                  found_data_reg, found_data_next;
    logic [7:0]            store_reg [FMT_BYTES_C];
    logic [7:0]            store_upd [FMT_BYTES_C];
    logic [7:0]            store_next [FMT_BYTES_C];

    // Results of this byte
    rwcp_pkg::kind_t       kind_v [2];
    logic [1:0]            n_res;
    logic                  first_v;
    logic                  do_complete;
    logic [31:0]           offset;
    logic [7:0]            fb [rwcp_pkg::FMT_FIELD_BYTES];
    rwcp_pkg::fmt_fields_t fmt_fields;
    rwcp_pkg::res_t        rec0, rec1;

    // Result queue
    rwcp_pkg::res_t                 q_reg [rwcp_pkg::QDEPTH];
    logic [rwcp_pkg::Q_PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [rwcp_pkg::Q_CNT_W-1:0]   count_reg;
    logic                           in_accept, out_pop;
    rwcp_pkg::res_t                 head;

    logic [7:0] b;
    assign b = s_axis_tdata;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_pop   = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_cnt_next   = byte_cnt_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        remaining_next  = remaining_reg;
        ctype_next      = ctype_reg;
        pad_next        = pad_reg;
        found_fmt_next  = found_fmt_reg;
        found_data_next = found_data_reg;
        store_upd       = store_reg;
        kind_v[0]       = rwcp_pkg::KIND_PCM;
        kind_v[1]       = rwcp_pkg::KIND_PCM;
        n_res           = 2'd0;
        first_v         = 1'b0;
        do_complete     = 1'b0;
        offset          = size_reg - remaining_reg;

        case (phase_reg)
            rwcp_pkg::PH_HEADER:
            begin
                id_next = {id_reg[23:0], b};
                if (byte_cnt_reg == rwcp_pkg::HDR_RIFF_LAST && id_next != rwcp_pkg::ID_RIFF)
                begin
                    phase_next = rwcp_pkg::PH_FAIL;
                    kind_v[n_res[0]] = rwcp_pkg::KIND_BAD_HDR;
                    n_res = n_res + 2'd1;
                end
                else if (byte_cnt_reg >= rwcp_pkg::HDR_LAST)
                begin
                    byte_cnt_next = 4'd0;
                    if (id_next != rwcp_pkg::ID_WAVE)
                    begin
                        phase_next = rwcp_pkg::PH_FAIL;
                        kind_v[n_res[0]] = rwcp_pkg::KIND_BAD_HDR;
                        n_res = n_res + 2'd1;
                    end
                    else
                    begin
                        phase_next = rwcp_pkg::PH_CHDR;
                    end
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            rwcp_pkg::PH_CHDR:
            begin
                if (byte_cnt_reg < rwcp_pkg::CHDR_ID_LEN)
                    id_next = {id_reg[23:0], b};
                else
                    size_next = {b, size_reg[31:8]};
                if (byte_cnt_reg >= rwcp_pkg::CHDR_LAST)
                begin
                    byte_cnt_next  = 4'd0;
                    remaining_next = size_next;
                    pad_next       = size_next[0];
                    if (id_next == rwcp_pkg::ID_FMT)
                    begin
                        ctype_next = rwcp_pkg::CT_FMT;
                        // zero only the part of the store this chunk will cover
                        for (int i = 0; i < FMT_BYTES_C; i++)
                        begin
                            if (size_next > 32'(i))
                                store_upd[i] = 8'd0;
                        end
                    end
                    else if (id_next == rwcp_pkg::ID_DATA)
                        ctype_next = rwcp_pkg::CT_DATA;
                    else
                        ctype_next = rwcp_pkg::CT_OTHER;
                    phase_next = rwcp_pkg::PH_PAYLOAD;
                    if (size_next == 32'd0)
                        do_complete = 1'b1;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            rwcp_pkg::PH_PAYLOAD:
            begin
                if (ctype_reg == rwcp_pkg::CT_FMT)
                begin
                    for (int i = 0; i < FMT_BYTES_C; i++)
                    begin
                        if (offset == 32'(i))
                            store_upd[i] = b;
                    end
                end
                else if (ctype_reg == rwcp_pkg::CT_DATA)
                begin
                    kind_v[n_res[0]] = rwcp_pkg::KIND_PCM;
                    n_res   = n_res + 2'd1;
                    first_v = (offset == 32'd0);
                end
                remaining_next = remaining_reg - 32'd1;
                if (remaining_next == 32'd0)
                    do_complete = 1'b1;
            end
            rwcp_pkg::PH_PAD:
            begin
                phase_next    = rwcp_pkg::PH_CHDR;
                byte_cnt_next = 4'd0;
            end
            default:
            begin
            end
        endcase

        if (do_complete)
        begin
            if (ctype_next == rwcp_pkg::CT_FMT)
            begin
                found_fmt_next = 1'b1;
                kind_v[n_res[0]] = rwcp_pkg::KIND_FMT;
                n_res = n_res + 2'd1;
            end
            else if (ctype_next == rwcp_pkg::CT_DATA)
            begin
                found_data_next = 1'b1;
            end
            byte_cnt_next = 4'd0;
            if (found_fmt_next && found_data_next)
            begin
                phase_next = rwcp_pkg::PH_DONE;
                kind_v[n_res[0]] = rwcp_pkg::KIND_DONE;
                n_res = n_res + 2'd1;
            end
            else
            begin
                phase_next = pad_next ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_CHDR;
            end
        end

        store_next = store_upd;
        if (s_axis_tlast)
        begin
            if (phase_next == rwcp_pkg::PH_HEADER)
            begin
                kind_v[n_res[0]] = rwcp_pkg::KIND_BAD_HDR;
                n_res = n_res + 2'd1;
            end
            else if (phase_next != rwcp_pkg::PH_DONE && phase_next != rwcp_pkg::PH_FAIL)
            begin
                // a payload cut short still counts as found
                if (phase_next == rwcp_pkg::PH_PAYLOAD)
                begin
                    if (ctype_next == rwcp_pkg::CT_FMT)
                    begin
                        found_fmt_next = 1'b1;
                        kind_v[n_res[0]] = rwcp_pkg::KIND_FMT;
                        n_res = n_res + 2'd1;
                    end
                    else if (ctype_next == rwcp_pkg::CT_DATA)
                    begin
                        found_data_next = 1'b1;
                    end
                end
                kind_v[n_res[0]] = (found_fmt_next && found_data_next) ?
                                   rwcp_pkg::KIND_DONE : rwcp_pkg::KIND_MISSING;
                n_res = n_res + 2'd1;
            end
            // back to reset state for the next file
            phase_next      = rwcp_pkg::PH_HEADER;
            byte_cnt_next   = 4'd0;
            id_next         = 32'd0;
            size_next       = 32'd0;
            remaining_next  = 32'd0;
            ctype_next      = rwcp_pkg::CT_OTHER;
            pad_next        = 1'b0;
            found_fmt_next  = 1'b0;
            found_data_next = 1'b0;
            for (int i = 0; i < FMT_BYTES_C; i++)
                store_next[i] = 8'd0;
        end
    end

    // Format field bytes; those the store lacks read as zero
    for (genvar p = 0; p < rwcp_pkg::FMT_FIELD_BYTES; p++)
    begin : g_fb
        if (p < FMT_BYTES_C)
        begin : g_st
            assign fb[p] = store_upd[p];
        end
        else
        begin : g_zero
            assign fb[p] = 8'd0;
        end
    end

    always_comb
    begin
        fmt_fields.format_tag    = {fb[1], fb[0]};
        fmt_fields.channel_count = {fb[3], fb[2]};
        fmt_fields.sample_rate   = {fb[7], fb[6], fb[5], fb[4]};
        fmt_fields.byte_rate     = {fb[11], fb[10], fb[9], fb[8]};
        fmt_fields.frame_align   = {fb[13], fb[12]};
        fmt_fields.sample_bits   = {fb[15], fb[14]};
        fmt_fields.extra_size    = {fb[17], fb[16]};

        // a pcm byte can only be the first result of a byte
        rec0.kind        = kind_v[0];
        rec0.pcm_byte    = (kind_v[0] == rwcp_pkg::KIND_PCM) ? b : 8'd0;
        rec0.chunk_first = (kind_v[0] == rwcp_pkg::KIND_PCM) ? first_v : 1'b0;
        rec0.fmt         = (kind_v[0] == rwcp_pkg::KIND_FMT) ? fmt_fields : '0;
        rec0.final_res   = (n_res == 2'd1);

        rec1.kind        = kind_v[1];
        rec1.pcm_byte    = 8'd0;
        rec1.chunk_first = 1'b0;
        rec1.fmt         = (kind_v[1] == rwcp_pkg::KIND_FMT) ? fmt_fields : '0;
        rec1.final_res   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rwcp_pkg::PH_HEADER;
            byte_cnt_reg   <= 4'd0;
            id_reg         <= 32'd0;
            size_reg       <= 32'd0;
            remaining_reg  <= 32'd0;
            ctype_reg      <= rwcp_pkg::CT_OTHER;
            pad_reg        <= 1'b0;
            found_fmt_reg  <= 1'b0;
            found_data_reg <= 1'b0;
            for (int i = 0; i < FMT_BYTES_C; i++)
                store_reg[i] <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            byte_cnt_reg   <= byte_cnt_next;
            id_reg         <= id_next;
            size_reg       <= size_next;
            remaining_reg  <= remaining_next;
            ctype_reg      <= ctype_next;
            pad_reg        <= pad_next;
            found_fmt_reg  <= found_fmt_next;
            found_data_reg <= found_data_next;
            store_reg      <= store_next;
        end
    end

    // Result queue: up to two pushes and one pop a cycle
    assign s_axis_tready = (count_reg <= rwcp_pkg::Q_CNT_W'(rwcp_pkg::QDEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (in_accept)
                wptr_reg <= wptr_reg + rwcp_pkg::Q_PTR_W'(n_res);
            if (out_pop)
                rptr_reg <= rptr_reg + rwcp_pkg::Q_PTR_W'(1);
            count_reg <= count_reg
                       + (in_accept ? rwcp_pkg::Q_CNT_W'(n_res) : '0)
                       - rwcp_pkg::Q_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && n_res != 2'd0)
            q_reg[wptr_reg] <= rec0;
        if (in_accept && n_res == 2'd2)
            q_reg[wptr_reg + rwcp_pkg::Q_PTR_W'(1)] <= rec1;
    end

    assign head          = q_reg[rptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.final_res;
    assign m_axis_tdata  = {7'd0,
                            head.fmt.extra_size,
                            head.fmt.sample_bits,
                            head.fmt.frame_align,
                            head.fmt.byte_rate,
                            head.fmt.sample_rate,
                            head.fmt.channel_count,
                            head.fmt.format_tag,
                            head.chunk_first,
                            head.pcm_byte};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rwcp_pkg::Q_CNT_W'(rwcp_pkg::QDEPTH))
        else $error("result queue overflow");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tlast) |=>
            (phase_reg == rwcp_pkg::PH_HEADER && !found_fmt_reg && !found_data_reg))
        else $error("parse state not restarted after end of file");

    a_both_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (found_fmt_reg && found_data_reg) |-> (phase_reg == rwcp_pkg::PH_DONE))
        else $error("both chunks found but parser not done");

    a_fmt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != rwcp_pkg::KIND_FMT) |->
            (m_axis_tdata[152:9] == '0))
        else $error("format fields set on a non-format result");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for riff_wave_chunk_parser_unit
// Feeds WAV files one byte a request and predicts each result record with its
// own chunk walker. Directed files cover the header checks, fmt capture, pad
// and skip handling, truncation and missing chunks. Random files follow under
// four idling phases.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [31:0] ID_LIST = 32'h4C49_5354;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    riff_wave_chunk_parser_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Expected result records, oldest first
    rwcp_pkg::res_t        parsed_results[$];
    // File under construction
    logic [7:0]            wav_file[$];
    int                    err_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;

    // Predictor state
    rwcp_pkg::phase_t      p_phase;
    logic [3:0]            p_count;
    logic [31:0]           p_id;
    logic [31:0]           p_size;
    logic [31:0]           p_left;
    rwcp_pkg::chunk_type_t p_ctype;
    logic                  p_pad;
    logic [7:0]            fmt_mem [0:rwcp_pkg::FMT_FIELD_BYTES-1];
    logic                  have_fmt;
    logic                  have_data;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_parse_state();
        p_phase   = rwcp_pkg::PH_HEADER;
        p_count   = '0;
        p_id      = '0;
        p_size    = '0;
        p_left    = '0;
        p_ctype   = rwcp_pkg::CT_OTHER;
        p_pad     = 1'b0;
        have_fmt  = 1'b0;
        have_data = 1'b0;
        for (int i = 0; i < rwcp_pkg::FMT_FIELD_BYTES; i++)
            fmt_mem[i] = 8'h00;
    endfunction

    function automatic void emit_result(rwcp_pkg::kind_t k, logic [7:0] pcm, logic first);
        rwcp_pkg::res_t r;
        r = '0;
        r.kind = k;
        if (k == rwcp_pkg::KIND_PCM)
        begin
            r.pcm_byte    = pcm;
            r.chunk_first = first;
        end
        if (k == rwcp_pkg::KIND_FMT)
        begin
            r.fmt.format_tag    = {fmt_mem[1], fmt_mem[0]};
            r.fmt.channel_count = {fmt_mem[3], fmt_mem[2]};
            r.fmt.sample_rate   = {fmt_mem[7], fmt_mem[6], fmt_mem[5], fmt_mem[4]};
            r.fmt.byte_rate     = {fmt_mem[11], fmt_mem[10], fmt_mem[9], fmt_mem[8]};
            r.fmt.frame_align   = {fmt_mem[13], fmt_mem[12]};
            r.fmt.sample_bits   = {fmt_mem[15], fmt_mem[14]};
            r.fmt.extra_size    = {fmt_mem[17], fmt_mem[16]};
        end
        parsed_results = {parsed_results, r};
    endfunction

    // Payload over, whole or cut short
    function automatic void chunk_found();
        if (p_ctype == rwcp_pkg::CT_FMT)
        begin
            have_fmt = 1'b1;
            emit_result(rwcp_pkg::KIND_FMT, 8'h00, 1'b0);
        end
        else if (p_ctype == rwcp_pkg::CT_DATA)
            have_data = 1'b1;
    endfunction

    function automatic void chunk_complete();
        chunk_found();
        p_count = '0;
        if (have_fmt && have_data)
        begin
            p_phase = rwcp_pkg::PH_DONE;
            emit_result(rwcp_pkg::KIND_DONE, 8'h00, 1'b0);
        end
        else
            p_phase = p_pad ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_CHDR;
    endfunction

    function automatic void parse_wav_byte(logic [7:0] b, logic eof);
        int          first_new;
        logic [31:0] offset;
        first_new = parsed_results.size();
        case (p_phase)
            rwcp_pkg::PH_HEADER:
            begin
                p_id = {p_id[23:0], b};
                if (p_count == rwcp_pkg::HDR_RIFF_LAST && p_id != rwcp_pkg::ID_RIFF)
                begin
                    p_phase = rwcp_pkg::PH_FAIL;
                    emit_result(rwcp_pkg::KIND_BAD_HDR, 8'h00, 1'b0);
                end
                else if (p_count >= rwcp_pkg::HDR_LAST)
                begin
                    p_count = '0;
                    if (p_id != rwcp_pkg::ID_WAVE)
                    begin
                        p_phase = rwcp_pkg::PH_FAIL;
                        emit_result(rwcp_pkg::KIND_BAD_HDR, 8'h00, 1'b0);
                    end
                    else
                        p_phase = rwcp_pkg::PH_CHDR;
                end
                else
                    p_count++;
            end
            rwcp_pkg::PH_CHDR:
            begin
                if (p_count < rwcp_pkg::CHDR_ID_LEN)
                    p_id = {p_id[23:0], b};
                else
                    p_size = {b, p_size[31:8]};
                if (p_count >= rwcp_pkg::CHDR_LAST)
                begin
                    p_count = '0;
                    p_left  = p_size;
                    p_pad   = p_size[0];
                    if (p_id == rwcp_pkg::ID_FMT)
                    begin
                        p_ctype = rwcp_pkg::CT_FMT;
                        // only the bytes this chunk will rewrite are cleared
                        for (int i = 0; i < rwcp_pkg::FMT_FIELD_BYTES; i++)
                            if (i < p_size)
                                fmt_mem[i] = 8'h00;
                    end
                    else if (p_id == rwcp_pkg::ID_DATA)
                        p_ctype = rwcp_pkg::CT_DATA;
                    else
                        p_ctype = rwcp_pkg::CT_OTHER;
                    p_phase = rwcp_pkg::PH_PAYLOAD;
                    if (p_left == 0)
                        chunk_complete();
                end
                else
                    p_count++;
            end
            rwcp_pkg::PH_PAYLOAD:
            begin
                offset = p_size - p_left;
                if (p_ctype == rwcp_pkg::CT_FMT)
                begin
                    if (offset < rwcp_pkg::FMT_FIELD_BYTES)
                        fmt_mem[offset] = b;
                end
                else if (p_ctype == rwcp_pkg::CT_DATA)
                    emit_result(rwcp_pkg::KIND_PCM, b, offset == 0);
                p_left--;
                if (p_left == 0)
                    chunk_complete();
            end
            rwcp_pkg::PH_PAD:
            begin
                p_phase = rwcp_pkg::PH_CHDR;
                p_count = '0;
            end
            default:
            begin
            end
        endcase

        if (eof)
        begin
            if (p_phase == rwcp_pkg::PH_HEADER)
                emit_result(rwcp_pkg::KIND_BAD_HDR, 8'h00, 1'b0);
            else if (p_phase != rwcp_pkg::PH_DONE && p_phase != rwcp_pkg::PH_FAIL)
            begin
                if (p_phase == rwcp_pkg::PH_PAYLOAD)
                    chunk_found();
                emit_result((have_fmt && have_data) ? rwcp_pkg::KIND_DONE
                                                    : rwcp_pkg::KIND_MISSING,
                            8'h00, 1'b0);
            end
            clear_parse_state();
        end

        if (parsed_results.size() > first_new)
            parsed_results[parsed_results.size() - 1].final_res = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("[%0t] %s mismatch: expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        rwcp_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (parsed_results.size() == 0)
            begin
                $display("[%0t] unexpected result: expected none, actual kind %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = parsed_results.pop_front();
                check_field("kind",          want.kind,              m_axis_tuser);
                check_field("pcm_byte",      want.pcm_byte,          m_axis_tdata[7:0]);
                check_field("chunk_first",   want.chunk_first,       m_axis_tdata[8]);
                check_field("format_tag",    want.fmt.format_tag,    m_axis_tdata[24:9]);
                check_field("channel_count", want.fmt.channel_count, m_axis_tdata[40:25]);
                check_field("sample_rate",   want.fmt.sample_rate,   m_axis_tdata[72:41]);
                check_field("byte_rate",     want.fmt.byte_rate,     m_axis_tdata[104:73]);
                check_field("frame_align",   want.fmt.frame_align,   m_axis_tdata[120:105]);
                check_field("sample_bits",   want.fmt.sample_bits,   m_axis_tdata[136:121]);
                check_field("extra_size",    want.fmt.extra_size,    m_axis_tdata[152:137]);
                check_field("final_res",     want.final_res,         m_axis_tlast);
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_wav_byte(b, eof);
    endtask

    function automatic void add_byte(logic [7:0] v);
        wav_file = {wav_file, v};
    endfunction

    function automatic void add_id(logic [31:0] id);
        for (int i = 3; i >= 0; i--)
            add_byte(id[8*i +: 8]);
    endfunction

    function automatic void add_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            add_byte(v[8*i +: 8]);
    endfunction

    function automatic void add_fill(int n, logic [7:0] v);
        for (int i = 0; i < n; i++)
            add_byte(v);
    endfunction

    function automatic void add_header();
        add_id(rwcp_pkg::ID_RIFF);
        add_le32($urandom);
        add_id(rwcp_pkg::ID_WAVE);
    endfunction

    // Sends the built file; tlast on its last byte
    task automatic send_file();
        for (int i = 0; i < wav_file.size(); i++)
            send_byte(wav_file[i], i == wav_file.size() - 1);
        wav_file.delete();
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_bad_header();
        // wrong first id, then a trailing byte that is ignored
        add_id(32'h5249_4658);
        add_byte(8'h00);
        send_file();
        // end of file on the very first byte
        add_byte(8'hFF);
        send_file();
        // good RIFF, wrong form type
        add_id(rwcp_pkg::ID_RIFF);
        add_le32(32'hFFFF_FFFF);
        add_id(32'h5741_5658);
        send_file();
        // cut inside the size field
        add_id(rwcp_pkg::ID_RIFF);
        add_fill(3, 8'h00);
        send_file();
    endtask

    task automatic test_empty_chunks();
        add_header();
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'h0);
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'h0);
        add_fill(2, 8'hFF);
        send_file();
    endtask

    task automatic test_format_capture();
        add_header();
        // oversize fmt: bytes past the store are dropped
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'd20);
        add_fill(20, 8'hFF);
        // shorter repeat only rewrites its own bytes; odd size, so a pad byte
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'd3);
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'hAA);
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'd2);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        send_file();
    endtask

    task automatic test_skip_and_pad();
        add_header();
        add_id(ID_LIST);
        add_le32(32'd5);
        add_fill(6, 8'h66);
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'd1);
        add_byte(8'h80);
        add_byte(8'h64);
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'd1);
        add_byte(8'h7F);
        add_byte(8'h00);
        // fmt ends on the end-of-file byte: format and done on one request
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'd16);
        for (int i = 0; i < 16; i++)
            add_byte(8'(i * 17));
        send_file();
    endtask

    task automatic test_truncation();
        // fmt cut short: format then chunk missing on the same request
        add_header();
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'd16);
        add_fill(5, 8'hC3);
        send_file();
        // huge data chunk cut short still counts as found
        add_header();
        add_id(rwcp_pkg::ID_FMT);
        add_le32(32'd0);
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'h8000_0001);
        add_fill(3, 8'h5A);
        send_file();
        // huge skipped chunk
        add_header();
        add_id(ID_LIST);
        add_le32(32'hFFFF_FFFF);
        add_fill(2, 8'h00);
        send_file();
    endtask

    task automatic test_missing_chunk();
        // data only, end of file as its last byte
        add_header();
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'd2);
        add_fill(2, 8'h11);
        send_file();
        // end of file on the pad byte
        add_header();
        add_id(rwcp_pkg::ID_DATA);
        add_le32(32'd1);
        add_fill(2, 8'h22);
        send_file();
        // end of file inside a chunk header
        add_header();
        add_id(rwcp_pkg::ID_FMT);
        add_fill(2, 8'h00);
        send_file();
    endtask

    // ------------------------------------------------------------------------
    // Random files
    // ------------------------------------------------------------------------
    function automatic void build_random_file();
        int          sel;
        int          n_chunks;
        int          cut;
        logic [31:0] cid;
        logic [31:0] sz;
        wav_file.delete();
        if ($urandom_range(99) < 8)
        begin
            // noise, sometimes with a good leading id
            if ($urandom_range(1))
                add_id(rwcp_pkg::ID_RIFF);
            for (int i = $urandom_range(1, 20); i > 0; i--)
                add_byte(8'($urandom));
            return;
        end
        add_header();
        if ($urandom_range(99) < 5)
            wav_file[$urandom_range(11)] = 8'($urandom);
        n_chunks = $urandom_range(1, 5);
        for (int c = 0; c < n_chunks; c++)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
                cid = rwcp_pkg::ID_FMT;
            else if (sel < 70)
                cid = rwcp_pkg::ID_DATA;
            else if (sel < 78)
                cid = ID_LIST;
            else if (sel < 88)
                cid = rwcp_pkg::ID_DATA ^ (32'h1 << $urandom_range(31));
            else
                cid = $urandom;

            if (cid == rwcp_pkg::ID_FMT)
            begin
                case ($urandom_range(3))
                    0:       sz = 32'd16;
                    1:       sz = 32'd18;
                    default: sz = $urandom_range(0, 24);
                endcase
            end
            else if (cid == rwcp_pkg::ID_DATA)
                sz = $urandom_range(0, 40);
            else
                sz = $urandom_range(0, 12);

            add_id(cid);
            if ($urandom_range(99) < 4)
            begin
                // big size: the file ends inside this payload
                add_le32({8'($urandom_range(1, 255)), 24'($urandom)});
                for (int i = $urandom_range(0, 8); i > 0; i--)
                    add_byte(8'($urandom));
                return;
            end
            add_le32(sz);
            for (int i = 0; i < sz; i++)
                add_byte(8'($urandom));
            if (sz[0])
                add_byte(8'($urandom));
        end
        if ($urandom_range(99) < 20)
        begin
            cut = $urandom_range(1, wav_file.size());
            while (wav_file.size() > cut)
                void'(wav_file.pop_back());
        end
        else if ($urandom_range(99) < 30)
        begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
                add_byte(8'($urandom));
        end
    endfunction

    task automatic test_random_files(input int idle_pct, input int stall_pct,
                                     input int byte_goal);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < byte_goal)
        begin
            build_random_file();
            sent += wav_file.size();
            send_file();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clear_parse_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_header();
        test_empty_chunks();
        test_format_capture();
        test_skip_and_pad();
        test_truncation();
        test_missing_chunk();

        test_random_files(0, 0, 300);
        test_random_files(83, 0, 300);
        test_random_files(0, 83, 300);
        test_random_files(22, 22, 300);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
